>>> design/efws_pkg.sv
// Package with the shared constants and types of the earliest-free-worker scheduler.
`timescale 1ns / 1ps
`default_nettype none
package efws_pkg;
	localparam int MAX_WORKERS = 64;
	localparam int TIME_BITS = 48;
	localparam int DUR_W = 30;
	localparam int IDX_W = 6;
	localparam int START_W = 48;
	localparam int CFG_W = 7;
	localparam int CFG_RESET = 64;
	localparam int CNT_W = $clog2(MAX_WORKERS + 1);
	localparam int WID_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	typedef struct packed {
		logic vld;
		logic [TIME_BITS-1:0] tm;
		logic [WID_W-1:0] idx;
	} tok_t;

	typedef struct packed {
		logic we;
		logic [WID_W-1:0] idx;
		logic [TIME_BITS-1:0] tm;
	} upd_t;
endpackage
`default_nettype wire

>>> design/efws_cell.sv
// One worker cell: holds a free-at time and keeps the earliest candidate moving down the chain.
`timescale 1ns / 1ps
`default_nettype none
module efws_cell
	import efws_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [WID_W-1:0] cell_id,
	input wire logic active,
	input wire tok_t tok_in,
	input wire upd_t upd,
	output tok_t tok_out
);
	logic [TIME_BITS-1:0] free_q;
	logic vld_q;
	logic [TIME_BITS-1:0] tm_q;
	logic [WID_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else if (upd.we && upd.idx == cell_id) begin
			free_q <= upd.tm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
		end
	end

	// A strictly earlier time wins, so on a tie the lower index from upstream is kept.
	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			if (active && free_q < tok_in.tm) begin
				tm_q <= free_q;
				idx_q <= cell_id;
			end else begin
				tm_q <= tok_in.tm;
				idx_q <= tok_in.idx;
			end
		end
	end

	assign tok_out = '{vld: vld_q, tm: tm_q, idx: idx_q};
endmodule
`default_nettype wire

>>> design/earliest_free_worker_scheduler_unit.sv
// Top level of the earliest-free-worker scheduler: control, cell chain and result stage.
// A job is issued by raising start with job_duration while busy is low; that edge is the
// transfer. The block then sends a search token down a chain of MAX_WORKERS cells, one
// cell per cycle, each holding one worker's free-at time. The token keeps the earliest
// active worker seen so far, lowest index on ties. After the last cell the winner's time
// is advanced by the duration (saturating) and written back into its cell.
// done is high for exactly one cycle with worker_index and start_time, registered from
// the token leaving the last cell. busy falls at the same edge, so the next start can be
// taken in the cycle done is high; no new job is taken before the last job's result is out.
// The receiver cannot stall; each result must be taken in its done cycle.
// cfg_we with cfg_wdata sets the number of active workers (0 acts as 1, values above
// MAX_WORKERS act as MAX_WORKERS); write it only while busy is low.
// Reset clears all free-at times to zero and sets the worker count to 64.
`timescale 1ns / 1ps
`default_nettype none
module earliest_free_worker_scheduler_unit
	import efws_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_W-1:0] cfg_wdata,
	input wire logic start,
	input wire logic [DUR_W-1:0] job_duration,
	output logic busy,
	output logic done,
	output logic [IDX_W-1:0] worker_index,
	output logic [START_W-1:0] start_time
);
	logic [CFG_W-1:0] active_workers_q;
	logic [CNT_W-1:0] wcnt;
	logic busy_q;
	logic done_q;
	logic [DUR_W-1:0] dur_q;
	logic [IDX_W-1:0] widx_q;
	logic [START_W-1:0] start_q;
	logic accept;
	tok_t chain [0:MAX_WORKERS];
	logic [MAX_WORKERS:0] tok_vld;
	logic [TIME_BITS:0] sum;
	upd_t upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_workers_q <= CFG_W'(CFG_RESET);
		end else if (cfg_we) begin
			active_workers_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (active_workers_q == '0) begin
			wcnt = CNT_W'(1);
		end else if (int'(active_workers_q) > MAX_WORKERS) begin
			wcnt = CNT_W'(MAX_WORKERS);
		end else begin
			wcnt = CNT_W'(active_workers_q);
		end
	end

	assign accept = start && !busy_q;
	assign chain[0] = '{vld: accept, tm: TIME_MAX, idx: '0};

	for (genvar k = 0; k < MAX_WORKERS; k++) begin : g_cell
		efws_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cell_id(WID_W'(k)),
			.active(CNT_W'(k) < wcnt),
			.tok_in(chain[k]),
			.upd(upd),
			.tok_out(chain[k+1])
		);
	end

	for (genvar k = 0; k <= MAX_WORKERS; k++) begin : g_vld
		assign tok_vld[k] = chain[k].vld;
	end

	assign sum = {1'b0, chain[MAX_WORKERS].tm} + (TIME_BITS + 1)'(dur_q);

	always_comb begin
		upd.we = chain[MAX_WORKERS].vld;
		upd.idx = chain[MAX_WORKERS].idx;
		upd.tm = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= chain[MAX_WORKERS].vld;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (chain[MAX_WORKERS].vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dur_q <= job_duration;
		end
		if (chain[MAX_WORKERS].vld) begin
			widx_q <= IDX_W'(chain[MAX_WORKERS].idx);
			start_q <= START_W'(chain[MAX_WORKERS].tm);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign worker_index = widx_q;
	assign start_time = start_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("More than one search token in the chain.");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("Result strobe without a job in progress.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("Start transfer did not mark the block busy.");

	a_idx_active: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (CNT_W'(worker_index) < wcnt))
		else $error("Job given to an inactive worker.");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_vld[MAX_WORKERS:1] != '0) |-> busy_q)
		else $error("Search token moving while the block is idle.");
endmodule
`default_nettype wire
